// ===== src/pcx_rle_planar_decoder_unit_macros.svh =====
// Assertion macros shared by the RLE planar decoder RTL.
`ifndef PCX_RLE_PLANAR_DECODER_UNIT_MACROS_SVH
`define PCX_RLE_PLANAR_DECODER_UNIT_MACROS_SVH

`ifndef ASSERT_OFF
`define PCXRLE_ASSERT_IMP(lbl, clk_s, rstn_s, cond, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (cond) |-> (prop)) \
    else $error(msg);
`define PCXRLE_ASSERT_NXT(lbl, clk_s, rstn_s, cond, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (cond) |=> (prop)) \
    else $error(msg);
`else
`define PCXRLE_ASSERT_IMP(lbl, clk_s, rstn_s, cond, prop, msg)
`define PCXRLE_ASSERT_NXT(lbl, clk_s, rstn_s, cond, prop, msg)
`endif

`endif

// ===== src/pcxrle_pkg.sv =====
// Package with the item types and constants of the RLE planar decoder.
package pcxrle_pkg;

  localparam int DEF_MAX_LINE_BYTES = 4096;
  localparam int BYTE_W = 8;
  localparam int CFG_W = 13;
  localparam int CFG_IDX_W = 2;
  localparam int PIX_W = 12;
  localparam int RUN_LEN_W = 6;

  localparam logic [CFG_IDX_W-1:0] REG_LINE_BYTES   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd2;

  localparam logic [CFG_W-1:0] CFG_RESET = 13'd1;
  localparam logic [BYTE_W-1:0] RUN_CODE_MIN = 8'd192;

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              start_of_image;
  } in_item_t;

  typedef struct packed {
    logic [BYTE_W-1:0] plane2_value;
    logic [BYTE_W-1:0] plane1_value;
    logic [BYTE_W-1:0] plane0_value;
    logic [PIX_W-1:0]  pixel_x;
    logic [PIX_W-1:0]  pixel_y;
    logic              last_of_run;
    logic              image_done;
  } out_item_t;

endpackage

// ===== src/pcxrle_line_store.sv =====
// Line store holding planes 0 and 1 of the current scanline.
module pcxrle_line_store #(
  parameter int MAX_LINE_BYTES = pcxrle_pkg::DEF_MAX_LINE_BYTES
) (
  input  logic                              clk,
  input  logic                              wr_en,
  input  logic                              wr_plane,
  input  logic [$clog2(MAX_LINE_BYTES)-1:0] wr_addr,
  input  logic [pcxrle_pkg::BYTE_W-1:0]     wr_data,
  input  logic                              rd_en,
  input  logic [$clog2(MAX_LINE_BYTES)-1:0] rd_addr,
  output logic [pcxrle_pkg::BYTE_W-1:0]     rd_data0,
  output logic [pcxrle_pkg::BYTE_W-1:0]     rd_data1
);
  import pcxrle_pkg::*;

  logic [BYTE_W-1:0] plane0_mem [MAX_LINE_BYTES];
  logic [BYTE_W-1:0] plane1_mem [MAX_LINE_BYTES];

  always_ff @(posedge clk) begin
    if (wr_en && !wr_plane) begin
      plane0_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data0 <= plane0_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en && wr_plane) begin
      plane1_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data1 <= plane1_mem[rd_addr];
    end
  end

endmodule

// ===== src/pcx_rle_planar_decoder_unit.sv =====
// Top level of the PCX run-length decoder for 24-bit planar images.
// The input channel carries one compressed byte per item, with a flag that
// restarts the image position. The output channel carries one packed pixel
// per item: the plane 2, plane 1 and plane 0 bytes with column and row.
// Configuration registers are written over the cfg port; the user must do so only
// while the block is idle, as the block does not enforce it. A literal byte is
// accepted, then placed while the input stalls. A run code only sets the run
// length; the byte after it is placed once per copy while the input stalls.
// Placing one byte is a single access to the line store, which has one
// write and one read port per plane; plane 2 bytes read planes 0 and 1.
// A pixel passes from the a registers to the h registers and on to the output
// register once the next placement of the item yields a pixel or is its final byte.
// A pixel is held until the next pixel or the item's final byte is placed,
// so copies after it that yield no pixel delay it.
// Reset clears position, run state and the pipeline, and sets all three
// registers to 1; line store contents stay undefined until written.
// When the receiver stalls, the output item holds, the pixel pipeline
// fills and placement pauses; the input then stalls as well.
module pcx_rle_planar_decoder_unit #(
  parameter int MAX_LINE_BYTES = pcxrle_pkg::DEF_MAX_LINE_BYTES
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  pcxrle_pkg::in_item_t                 in_item,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output pcxrle_pkg::out_item_t                out_item,
  input  logic                                 cfg_wr_en,
  input  logic [pcxrle_pkg::CFG_IDX_W-1:0]     cfg_addr,
  input  logic [pcxrle_pkg::CFG_W-1:0]         cfg_wdata
);
  import pcxrle_pkg::*;

`include "pcx_rle_planar_decoder_unit_macros.svh"

  localparam int X_W = $clog2(MAX_LINE_BYTES);
  localparam int LEN_W = $clog2(MAX_LINE_BYTES + 1);
  localparam int CMP_W = (LEN_W > CFG_W + 1) ? LEN_W : CFG_W + 1;
  localparam logic [CMP_W-1:0] MAX_LEN = CMP_W'(MAX_LINE_BYTES);
  localparam logic [1:0] PLANE_LAST = 2'd2;

  logic [CFG_W-1:0]     line_bytes_r;
  logic [CFG_W-1:0]     image_width_r;
  logic [CFG_W-1:0]     image_height_r;

  logic [X_W-1:0]       byte_in_plane_r;
  logic [1:0]           plane_index_r;
  logic [CFG_W-1:0]     row_count_r;
  logic                 run_pending_r;
  logic [RUN_LEN_W-1:0] run_length_r;

  logic                 busy_r;
  logic [RUN_LEN_W-1:0] rem_r;
  logic [BYTE_W-1:0]    byte_r;

  logic                 a_valid_r;
  logic                 a_pix_r;
  logic                 a_end_r;
  logic [BYTE_W-1:0]    a_byte_r;
  logic [PIX_W-1:0]     a_x_r;
  logic [PIX_W-1:0]     a_y_r;
  logic                 a_done_r;

  logic                 h_valid_r;
  logic                 h_known_r;
  logic [BYTE_W-1:0]    h_p2_r;
  logic [BYTE_W-1:0]    h_p1_r;
  logic [BYTE_W-1:0]    h_p0_r;
  logic [PIX_W-1:0]     h_x_r;
  logic [PIX_W-1:0]     h_y_r;
  logic                 h_done_r;

  logic                 out_valid_r;
  out_item_t            out_item_r;

  logic                 in_accept;
  logic                 out_free;
  logic                 h_go;
  logic                 a_take;
  logic                 issue;
  logic                 drop;
  logic                 pix;
  logic                 done_c;
  logic                 run_pend_eff;
  logic [CMP_W-1:0]     lb_ext;
  logic [CMP_W-1:0]     len_c;
  logic [CMP_W-1:0]     x_ext;
  logic [CMP_W-1:0]     x_use_ext;
  logic [CMP_W-1:0]     x_inc;
  logic [CMP_W-1:0]     width_ext;
  logic [CMP_W-1:0]     lim_c;
  logic [X_W-1:0]       x_use;
  logic                 mem_wr_en;
  logic                 mem_rd_en;
  logic [BYTE_W-1:0]    mem_rd0;
  logic [BYTE_W-1:0]    mem_rd1;

  assign in_accept = in_valid && !in_stall;
  assign in_stall  = busy_r;
  assign out_free  = !out_valid_r || !out_stall;
  assign h_go      = h_valid_r && out_free && (h_known_r || (a_valid_r && a_pix_r));
  assign a_take    = a_valid_r && (!a_pix_r || !h_valid_r || h_go);
  assign issue     = busy_r && (!a_valid_r || a_take);
  assign run_pend_eff = run_pending_r && !in_item.start_of_image;

  always_comb begin
    lb_ext = CMP_W'(line_bytes_r);
    if (lb_ext == '0) begin
      len_c = CMP_W'(1);
    end else if (lb_ext > MAX_LEN) begin
      len_c = MAX_LEN;
    end else begin
      len_c = lb_ext;
    end
    x_ext = CMP_W'(byte_in_plane_r);
    if (x_ext >= len_c) begin
      x_use_ext = len_c - CMP_W'(1);
    end else begin
      x_use_ext = x_ext;
    end
    x_use     = x_use_ext[X_W-1:0];
    x_inc     = x_use_ext + CMP_W'(1);
    width_ext = CMP_W'(image_width_r);
    lim_c     = (width_ext < len_c) ? width_ext : len_c;
    drop      = row_count_r >= image_height_r;
    pix       = !drop && (plane_index_r == PLANE_LAST) && (x_use_ext < width_ext);
    done_c    = ((CMP_W'(row_count_r) + CMP_W'(1)) == CMP_W'(image_height_r)) &&
                (x_inc == lim_c);
    mem_wr_en = issue && !drop && (plane_index_r != PLANE_LAST);
    mem_rd_en = issue && pix;
  end

  pcxrle_line_store #(
    .MAX_LINE_BYTES(MAX_LINE_BYTES)
  ) u_line_store (
    .clk      (clk),
    .wr_en    (mem_wr_en),
    .wr_plane (plane_index_r[0]),
    .wr_addr  (x_use),
    .wr_data  (byte_r),
    .rd_en    (mem_rd_en),
    .rd_addr  (x_use),
    .rd_data0 (mem_rd0),
    .rd_data1 (mem_rd1)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_bytes_r   <= CFG_RESET;
      image_width_r  <= CFG_RESET;
      image_height_r <= CFG_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        REG_LINE_BYTES:   line_bytes_r   <= cfg_wdata;
        REG_IMAGE_WIDTH:  image_width_r  <= cfg_wdata;
        REG_IMAGE_HEIGHT: image_height_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_in_plane_r <= '0;
      plane_index_r   <= '0;
      row_count_r     <= '0;
      run_pending_r   <= 1'b0;
      run_length_r    <= '0;
      busy_r          <= 1'b0;
      rem_r           <= '0;
    end else if (in_accept) begin
      if (in_item.start_of_image) begin
        byte_in_plane_r <= '0;
        plane_index_r   <= '0;
        row_count_r     <= '0;
      end
      if (run_pend_eff) begin
        run_pending_r <= 1'b0;
        run_length_r  <= '0;
        busy_r        <= (run_length_r != '0);
        rem_r         <= run_length_r;
      end else if (in_item.data_byte < RUN_CODE_MIN) begin
        run_pending_r <= 1'b0;
        run_length_r  <= '0;
        busy_r        <= 1'b1;
        rem_r         <= RUN_LEN_W'(1);
      end else begin
        run_pending_r <= 1'b1;
        run_length_r  <= in_item.data_byte[RUN_LEN_W-1:0];
      end
    end else if (issue) begin
      rem_r <= rem_r - RUN_LEN_W'(1);
      if (rem_r == RUN_LEN_W'(1)) begin
        busy_r <= 1'b0;
      end
      if (!drop) begin
        if (x_inc >= len_c) begin
          byte_in_plane_r <= '0;
          if (plane_index_r == PLANE_LAST) begin
            plane_index_r <= '0;
            row_count_r   <= row_count_r + CFG_W'(1);
          end else begin
            plane_index_r <= plane_index_r + 2'd1;
          end
        end else begin
          byte_in_plane_r <= x_inc[X_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      byte_r <= in_item.data_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (issue) begin
      a_valid_r <= 1'b1;
    end else if (a_take) begin
      a_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      a_pix_r  <= pix;
      a_end_r  <= (rem_r == RUN_LEN_W'(1));
      a_byte_r <= byte_r;
      a_x_r    <= x_use_ext[PIX_W-1:0];
      a_y_r    <= row_count_r[PIX_W-1:0];
      a_done_r <= done_c;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      h_valid_r <= 1'b0;
      h_known_r <= 1'b0;
    end else if (a_take && a_pix_r) begin
      h_valid_r <= 1'b1;
      h_known_r <= a_end_r;
    end else if (h_go) begin
      h_valid_r <= 1'b0;
      h_known_r <= 1'b0;
    end else if (a_take && a_end_r && h_valid_r) begin
      h_known_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (a_take && a_pix_r) begin
      h_p2_r   <= a_byte_r;
      h_p1_r   <= mem_rd1;
      h_p0_r   <= mem_rd0;
      h_x_r    <= a_x_r;
      h_y_r    <= a_y_r;
      h_done_r <= a_done_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (h_go) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (h_go) begin
      out_item_r.plane2_value <= h_p2_r;
      out_item_r.plane1_value <= h_p1_r;
      out_item_r.plane0_value <= h_p0_r;
      out_item_r.pixel_x      <= h_x_r;
      out_item_r.pixel_y      <= h_y_r;
      out_item_r.last_of_run  <= h_known_r;
      out_item_r.image_done   <= h_done_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  `PCXRLE_ASSERT_IMP(a_held_pixel_resolves, clk, rst_n, h_valid_r && !h_known_r,
    busy_r || a_valid_r, "held pixel has no pending end of item")
  `PCXRLE_ASSERT_IMP(a_busy_has_count, clk, rst_n, busy_r,
    rem_r != '0, "busy with zero remaining placements")
  `PCXRLE_ASSERT_IMP(a_plane_range, clk, rst_n, 1'b1,
    plane_index_r != 2'd3, "plane index beyond plane 2")
  `PCXRLE_ASSERT_IMP(a_done_is_last, clk, rst_n, out_valid_r && out_item_r.image_done,
    out_item_r.last_of_run, "final image pixel not marked last of item")

endmodule

// ===== dv/pcx_rle_planar_decoder_unit_tb.sv =====
// Self-checking testbench for the PCX RLE planar decoder with a built-in pixel predictor.
module pcx_rle_planar_decoder_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pcxrle_pkg::*;

  localparam int MAX_LINE = DEF_MAX_LINE_BYTES;
  localparam int MAX_RUN = 63;
  localparam int DRAIN_CYCLES = 100;
  localparam int STUCK_LIMIT = 5000;
  localparam int PHASES = 8;

  typedef struct packed {
    logic                 is_reg;
    logic [CFG_IDX_W-1:0] reg_idx;
    logic [CFG_W-1:0]     reg_val;
    in_item_t             item;
    logic                 typed;
    out_item_t            px;
  } step_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_item = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_item;
  logic cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_addr = '0;
  logic [CFG_W-1:0] cfg_wdata = '0;

  logic [7:0] plane_store [2*MAX_LINE];
  int unsigned col_pos;
  int unsigned plane_sel;
  int unsigned row_pos;
  bit run_armed;
  int unsigned run_copies;
  logic [CFG_W-1:0] line_reg;
  logic [CFG_W-1:0] width_reg;
  logic [CFG_W-1:0] height_reg;

  out_item_t fresh_px[$];
  out_item_t pending_pixels[$];
  step_t steps[$];
  out_item_t want;
  int fault_count = 0;
  int idle_cycles = 0;
  bit calm = 1'b0;

  int phase_lb [PHASES] = '{3, 2, 5, 1, 0, 64, 0, 0};
  int phase_w  [PHASES] = '{3, 1, 7, 1, 0, 64, 0, 2};
  int phase_h  [PHASES] = '{4, 6, 3, 8, 0, 2, 0, 3};

  pcx_rle_planar_decoder_unit uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_item(in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item(out_item),
    .cfg_wr_en(cfg_wr_en),
    .cfg_addr(cfg_addr),
    .cfg_wdata(cfg_wdata)
  );

  always #6 clk = ~clk;

  function automatic int unsigned line_len();
    if (line_reg == 0) return 1;
    if (line_reg > MAX_LINE) return MAX_LINE;
    return line_reg;
  endfunction

  function automatic bit place_byte(logic [7:0] b, output out_item_t px);
    int unsigned len;
    int unsigned x;
    int unsigned lim;
    bit made;
    len = line_len();
    x = col_pos;
    made = 1'b0;
    px = '0;
    if (row_pos >= height_reg) return 1'b0;
    if (x >= len) x = len - 1;
    if (plane_sel < 2) begin
      plane_store[plane_sel * MAX_LINE + x] = b;
    end else if (x < width_reg) begin
      lim = (width_reg < len) ? width_reg : len;
      px.plane2_value = b;
      px.plane1_value = plane_store[MAX_LINE + x];
      px.plane0_value = plane_store[x];
      px.pixel_x = x[PIX_W-1:0];
      px.pixel_y = row_pos[PIX_W-1:0];
      px.last_of_run = 1'b0;
      px.image_done = (row_pos + 1 == height_reg) && (x == lim - 1);
      made = 1'b1;
    end
    x++;
    if (x >= len) begin
      x = 0;
      plane_sel++;
      if (plane_sel >= 3) begin
        plane_sel = 0;
        row_pos++;
      end
    end
    col_pos = x;
    return made;
  endfunction

  // The last pixel of an item is held back so that it can carry last_of_run.
  function automatic void decode_item(in_item_t it);
    out_item_t px;
    out_item_t held;
    bit have;
    have = 1'b0;
    held = '0;
    fresh_px.delete();
    if (it.start_of_image) begin
      col_pos = 0;
      plane_sel = 0;
      row_pos = 0;
      run_armed = 1'b0;
      run_copies = 0;
    end
    if (run_armed) begin
      for (int k = 0; k < run_copies; k++) begin
        if (place_byte(it.data_byte, px)) begin
          if (have) fresh_px.push_back(held);
          held = px;
          have = 1'b1;
        end
      end
      run_armed = 1'b0;
      run_copies = 0;
    end else if (it.data_byte < RUN_CODE_MIN) begin
      if (place_byte(it.data_byte, px)) begin
        held = px;
        have = 1'b1;
      end
    end else begin
      run_copies = it.data_byte - RUN_CODE_MIN;
      run_armed = 1'b1;
    end
    if (have) begin
      held.last_of_run = 1'b1;
      fresh_px.push_back(held);
    end
  endfunction

  function automatic void add_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    step_t s;
    s = '0;
    s.is_reg = 1'b1;
    s.reg_idx = idx;
    s.reg_val = val;
    steps.push_back(s);
  endfunction

  function automatic void add_byte(logic [7:0] data, logic soi);
    step_t s;
    s = '0;
    s.item.data_byte = data;
    s.item.start_of_image = soi;
    steps.push_back(s);
  endfunction

  // A lone pixel that both starts at the origin and finishes the image.
  function automatic void add_pixel(logic [7:0] data, logic soi, logic [7:0] p1,
                                    logic [7:0] p0);
    step_t s;
    s = '0;
    s.item.data_byte = data;
    s.item.start_of_image = soi;
    s.typed = 1'b1;
    s.px.plane2_value = data;
    s.px.plane1_value = p1;
    s.px.plane0_value = p0;
    s.px.last_of_run = 1'b1;
    s.px.image_done = 1'b1;
    steps.push_back(s);
  endfunction

  function automatic void note_fault(string what, out_item_t exp_px, out_item_t got);
    fault_count++;
    if (fault_count <= 10) begin
      $display("%s: expected p2=%h p1=%h p0=%h x=%0d y=%0d last=%b done=%b", what,
               exp_px.plane2_value, exp_px.plane1_value, exp_px.plane0_value,
               exp_px.pixel_x, exp_px.pixel_y, exp_px.last_of_run, exp_px.image_done);
      $display("    got p2=%h p1=%h p0=%h x=%0d y=%0d last=%b done=%b",
               got.plane2_value, got.plane1_value, got.plane0_value,
               got.pixel_x, got.pixel_y, got.last_of_run, got.image_done);
    end
  endfunction

  task automatic quiesce();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    unique case (idx)
      REG_LINE_BYTES:   line_reg = val;
      REG_IMAGE_WIDTH:  width_reg = val;
      REG_IMAGE_HEIGHT: height_reg = val;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_config(int lb, int w, int h);
    quiesce();
    write_reg(REG_LINE_BYTES, lb[CFG_W-1:0]);
    write_reg(REG_IMAGE_WIDTH, w[CFG_W-1:0]);
    write_reg(REG_IMAGE_HEIGHT, h[CFG_W-1:0]);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic send_item(in_item_t it, logic typed, out_item_t typed_px);
    while (!calm && $urandom_range(0, 99) < 7) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    decode_item(it);
    if (typed) pending_pixels.push_back(typed_px);
    else foreach (fresh_px[i]) pending_pixels.push_back(fresh_px[i]);
  endtask

  // Mostly literals and run pairs; a few restarts, some of them cutting a run short.
  task automatic run_stream(int count, int hold_at);
    in_item_t it;
    int k;
    int r;
    bit held;
    k = 0;
    held = 1'b0;
    while (k < count) begin
      if (hold_at >= 0 && k >= hold_at && !held) begin
        quiesce();
        held = 1'b1;
      end
      r = $urandom_range(0, 99);
      it.data_byte = 8'($urandom_range(0, 255));
      it.start_of_image = (k == 0) || (r < 8);
      if (!it.start_of_image && r < 55) begin
        it.data_byte = 8'($urandom_range(0, RUN_CODE_MIN - 1));
      end else if (!it.start_of_image) begin
        it.data_byte = RUN_CODE_MIN + 8'($urandom_range(0, MAX_RUN));
        send_item(it, 1'b0, '0);
        k++;
        it.data_byte = 8'($urandom_range(0, 255));
        it.start_of_image = ($urandom_range(0, 99) < 5);
      end
      send_item(it, 1'b0, '0);
      k++;
    end
  endtask

  always @(posedge clk) begin
    out_stall <= !calm && ($urandom_range(0, 99) < 7);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_pixels.size() == 0) begin
        note_fault("unexpected pixel", '0, out_item);
      end else begin
        want = pending_pixels.pop_front();
        if (out_item.plane2_value !== want.plane2_value ||
            out_item.plane1_value !== want.plane1_value ||
            out_item.plane0_value !== want.plane0_value ||
            out_item.pixel_x !== want.pixel_x ||
            out_item.pixel_y !== want.pixel_y ||
            out_item.last_of_run !== want.last_of_run ||
            out_item.image_done !== want.image_done)
          note_fault("pixel mismatch", want, out_item);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STUCK_LIMIT) begin
        $display("[pcx_rle_planar_decoder_unit] ERROR");
        $finish;
      end
    end
  end

  initial begin
    col_pos = 0;
    plane_sel = 0;
    row_pos = 0;
    run_armed = 1'b0;
    run_copies = 0;
    line_reg = CFG_RESET;
    width_reg = CFG_RESET;
    height_reg = CFG_RESET;

    add_byte(8'h11, 1'b0);
    add_byte(8'h22, 1'b0);
    add_pixel(8'h33, 1'b0, 8'h22, 8'h11);
    add_byte(8'h44, 1'b0);
    add_byte(8'hC3, 1'b1);
    add_pixel(8'hAB, 1'b0, 8'hAB, 8'hAB);
    add_byte(8'hC0, 1'b1);
    add_byte(8'hFF, 1'b0);
    add_byte(8'hC5, 1'b1);
    add_byte(8'h00, 1'b1);
    add_byte(8'hBF, 1'b0);
    add_byte(8'hFF, 1'b0);
    add_pixel(8'h80, 1'b0, 8'hBF, 8'h00);
    add_reg(REG_LINE_BYTES, 13'd0);
    add_reg(REG_IMAGE_WIDTH, 13'd0);
    add_reg(REG_IMAGE_HEIGHT, 13'd3);
    add_byte(8'hC9, 1'b1);
    add_byte(8'h5A, 1'b0);
    add_reg(REG_IMAGE_WIDTH, 13'd1);
    add_byte(8'hC6, 1'b1);
    add_byte(8'h7E, 1'b0);
    add_reg(REG_IMAGE_HEIGHT, 13'd0);
    add_byte(8'h01, 1'b1);
    add_reg(REG_LINE_BYTES, 13'h1FFF);
    add_reg(REG_IMAGE_WIDTH, 13'h1FFF);
    add_reg(REG_IMAGE_HEIGHT, 13'h1FFF);
    add_byte(8'hFF, 1'b1);
    add_byte(8'h12, 1'b0);
    add_byte(8'hFF, 1'b0);
    add_byte(8'h34, 1'b0);

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (steps[i]) begin
      if (steps[i].is_reg) begin
        quiesce();
        write_reg(steps[i].reg_idx, steps[i].reg_val);
        cfg_wr_en <= 1'b0;
      end else begin
        send_item(steps[i].item, steps[i].typed, steps[i].px);
      end
    end

    phase_lb[4] = $urandom_range(0, 8);
    phase_w[4] = $urandom_range(0, 10);
    phase_h[4] = $urandom_range(0, 6);
    phase_lb[6] = $urandom_range(0, 8);
    phase_w[6] = $urandom_range(0, 10);
    phase_h[6] = $urandom_range(0, 6);

    for (int p = 0; p < PHASES; p++) begin
      calm = (p == 2);
      set_config(phase_lb[p], phase_w[p], phase_h[p]);
      run_stream(40, (p == 1) ? 20 : -1);
    end
    calm = 1'b0;

    quiesce();
    if (fault_count == 0 && pending_pixels.size() == 0) begin
      $display("[pcx_rle_planar_decoder_unit] OK");
    end else begin
      $display("[pcx_rle_planar_decoder_unit] ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+src
src/pcxrle_pkg.sv
src/pcxrle_line_store.sv
src/pcx_rle_planar_decoder_unit.sv
dv/pcx_rle_planar_decoder_unit_tb.sv
